/* design/csps_pkg.sv */
// ----------------------------------------------------------------------------
// csps_pkg: shared constants and helpers for the checkered sphere shader
// Fixed-point constants, the width correction table, signed divide by a
// power of two with truncation toward zero, and the checker edge ramp.
// ----------------------------------------------------------------------------
package csps_pkg;

  // q13 fixed point: one unit is 8192
  localparam logic [5:0] FRAC_SH  = 6'd13;
  localparam logic [5:0] WGT_SH   = 6'd8;
  localparam logic [5:0] CHK_SH   = 6'd7;
  localparam logic [5:0] ASIN_SH  = 6'd3;

  // rotation by a fixed tilt angle (cos and sin in q13)
  localparam int ROT_COS = 8028;
  localparam int ROT_SIN = 1627;

  // arcsine polynomial coefficients
  localparam int ASIN_LIN = 11;
  localparam int ASIN_C3  = 1365;
  localparam int ASIN_C5  = 614;

  // sphere radius squared and width table limit
  localparam int RAD_LIMIT  = 1 << 26;
  localparam int WIDTH_SAT  = 8191;

  // rim darkening window on the radius squared in units of 16384
  localparam int RIM_EDGE   = 4096;
  localparam int RIM_START  = 3840;
  localparam int RIM_FULL   = 256;

  // checker and color constants
  localparam int CHK_MID    = 128;
  localparam int RED_FULL   = 31;
  localparam int GRN_FULL   = 63;
  localparam int BLU_FULL   = 31;

  // 1/cos width correction, 33 entries, indexed by |y| / 256
  localparam logic [15:0] WIDTH_TAB [0:32] = '{
    16'd8192,  16'd8196,  16'd8208,  16'd8228,  16'd8256,  16'd8293,  16'd8339,
    16'd8395,  16'd8460,  16'd8536,  16'd8623,  16'd8723,  16'd8836,  16'd8965,
    16'd9110,  16'd9273,  16'd9459,  16'd9669,  16'd9908,  16'd10180, 16'd10494,
    16'd10856, 16'd11280, 16'd11782, 16'd12385, 16'd13123, 16'd14052, 16'd15262,
    16'd16921, 16'd19378, 16'd23541, 16'd33027, 16'd65535
  };

  // side info that rides alongside the texture pipeline
  typedef struct packed {
    logic       outside;
    logic [8:0] rim;
  } csps_side_t;

  // signed divide by 2**sh, truncating toward zero
  function automatic logic signed [39:0] sdiv_pow2(input logic signed [39:0] v,
                                                    input logic [5:0] sh);
    logic signed [39:0] bias;
    bias = v[39] ? ((40'sd1 <<< sh) - 40'sd1) : 40'sd0;
    return (v + bias) >>> sh;
  endfunction

  // soft checker edge: 256 near t = 0 and from t = 4352 up, 0 from 256 to 4095, linear ramps between
  function automatic logic [8:0] edge_ramp(input logic [12:0] t);
    logic [8:0] r;
    if (t < 13'd256) begin
      r = 9'(13'd256 - t);
    end else if (t < 13'd4096) begin
      r = 9'd0;
    end else if (t < 13'd4352) begin
      r = 9'(t - 13'd4096);
    end else begin
      r = 9'd256;
    end
    return r;
  endfunction

endpackage

/* design/csps_asin.sv */
// ----------------------------------------------------------------------------
// csps_asin: pipelined arcsine polynomial with wraparound offset
// Computes v' = 11v/8, then v' + (1365 v'^3 + 614 v'^5) / 8192 in q13,
// adds an offset and wraps to 13 bits. Nine register stages, one word a cycle.
// ----------------------------------------------------------------------------
module csps_asin
  import csps_pkg::*;
(
  input  logic               clk,
  input  logic signed [15:0] v,
  input  logic        [12:0] offset,
  output logic        [12:0] t
);

  // stage registers
  logic signed [15:0] a1, a2_a, a3_a, a4_a, a5_a, a6_a, a7_a, a8_a;
  logic        [15:0] sq2, sq3, sq4;
  logic signed [31:0] p3;
  logic signed [18:0] c4;
  logic signed [35:0] p5;
  logic signed [29:0] m3_5, m3_6, m3_7;
  logic signed [22:0] c6;
  logic signed [32:0] m5_7;
  logic signed [33:0] sum8;
  logic        [12:0] off1, off2, off3, off4, off5, off6, off7, off8;

  // combinational helpers
  logic signed [31:0] sq_full;
  logic        [12:0] q_low;

  always_comb begin
    sq_full = 32'(a1) * 32'(a1);
    q_low   = 13'(sdiv_pow2(40'(sum8), FRAC_SH));
  end

  // stage 1: linear stretch
  always_ff @(posedge clk) begin
    a1   <= 16'(sdiv_pow2(40'(v) * 40'(ASIN_LIN), ASIN_SH));
    off1 <= offset;
  end

  // stage 2: square
  always_ff @(posedge clk) begin
    sq2  <= 16'(sq_full >>> FRAC_SH);
    a2_a <= a1;
    off2 <= off1;
  end

  // stage 3: cube product
  always_ff @(posedge clk) begin
    p3   <= 32'(signed'({1'b0, sq2})) * 32'(a2_a);
    sq3  <= sq2;
    a3_a <= a2_a;
    off3 <= off2;
  end

  // stage 4: cube scaled
  always_ff @(posedge clk) begin
    c4   <= 19'(sdiv_pow2(40'(p3), FRAC_SH));
    sq4  <= sq3;
    a4_a <= a3_a;
    off4 <= off3;
  end

  // stage 5: fifth power product and cubic term
  always_ff @(posedge clk) begin
    p5   <= 36'(signed'({1'b0, sq4})) * 36'(c4);
    m3_5 <= 30'(ASIN_C3) * 30'(c4);
    a5_a <= a4_a;
    off5 <= off4;
  end

  // stage 6: fifth power scaled
  always_ff @(posedge clk) begin
    c6   <= 23'(sdiv_pow2(40'(p5), FRAC_SH));
    m3_6 <= m3_5;
    a6_a <= a5_a;
    off6 <= off5;
  end

  // stage 7: quintic term
  always_ff @(posedge clk) begin
    m5_7 <= 33'(ASIN_C5) * 33'(c6);
    m3_7 <= m3_6;
    a7_a <= a6_a;
    off7 <= off6;
  end

  // stage 8: polynomial sum
  always_ff @(posedge clk) begin
    sum8 <= 34'(m3_7) + 34'(m5_7);
    a8_a <= a7_a;
    off8 <= off7;
  end

  // stage 9: final sum, wrap to 13 bits
  always_ff @(posedge clk) begin
    t <= 13'(a8_a) + q_low + off8;
  end

endmodule

/* design/checkered_sphere_pixel_shader.sv */
// ----------------------------------------------------------------------------
// checkered_sphere_pixel_shader: per-pixel shader for a rotating checker sphere
// Rotates the centred pixel, tests it against the sphere, corrects width,
// maps both axes through an arcsine polynomial, forms a soft checker and
// darkens the rim. Output is RGB565.
// ----------------------------------------------------------------------------
//
//   channel   ports                              handshake
//   -------   --------------------------------   ------------------------------
//   command   start, pixel_x, pixel_y, phase     taken when start & !busy
//   result    done, outside, colour              done high for one cycle
//
// One pixel is taken every clock cycle; busy is always low.
// A pixel's valid bit runs down a shift register as deep as the rotate, radius,
// width, arcsine and checker pipeline, so done rises with its result.
// Reset clears the valid bits of the pipeline only; data registers run free.
// The receiver takes every result, so nothing in the pipeline ever stalls.
// ----------------------------------------------------------------------------
module checkered_sphere_pixel_shader
  import csps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [14:0] pixel_x,
  input  logic [14:0] pixel_y,
  input  logic [12:0] phase,
  output logic        busy,
  output logic        done,
  output logic        outside,
  output logic [15:0] colour
);

  localparam int NUM_STAGES = 21;
  localparam int SIDE_DEPTH = 13;

  // valid bits, one per stage
  logic [NUM_STAGES-1:0] vld;

  // front end stage registers
  logic signed [13:0] s1_sx, s1_sy;
  logic        [12:0] s1_ph, s2_ph, s3_ph, s4_ph, s5_ph, s6_ph, s7_ph;
  logic signed [27:0] s2_px, s2_py;
  logic signed [14:0] s3_rx, s3_ry, s4_rx, s4_ry, s5_rx, s5_ry, s6_ry;
  logic        [26:0] s4_rx2, s4_ry2;
  logic        [23:0] s4_wa, s4_wb;
  logic        [27:0] s5_rad;
  logic        [15:0] s5_wc;
  logic signed [31:0] s6_txp;
  csps_side_t         s6_side, s7_side;
  logic signed [15:0] s7_tx, s7_ty;

  // side info delay line alongside the arcsine pipelines
  csps_side_t side_dly [0:SIDE_DEPTH-1];

  // texture coordinates out of the arcsine pipelines
  logic [12:0] tex_x, tex_y;

  // checker and color stage registers
  logic        [8:0]  c1_cx, c1_cy;
  logic signed [17:0] c2_pc;
  logic        [8:0]  c3_cc;
  logic        [5:0]  c4_g;
  logic        [4:0]  c4_b;

  // combinational helpers
  logic signed [29:0] rx_sq, ry_sq;
  logic        [14:0] ry_abs;
  logic        [12:0] ry_sat;
  logic        [4:0]  wm;
  logic        [7:0]  wf;
  logic        [24:0] wsum;
  logic        [13:0] rad_q;
  logic        [8:0]  rim_val;
  logic signed [9:0]  dx, dy;
  logic        [13:0] red_p, grn_p, blu_p;

  assign busy = 1'b0;
  assign done = vld[NUM_STAGES-1];

  // valid shift register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NUM_STAGES-2:0], start & ~busy};
    end
  end

  // stage 1: halve and centre, (x >> 1) - 8192 is the top bit flipped
  always_ff @(posedge clk) begin
    s1_sx <= signed'({~pixel_x[14], pixel_x[13:1]});
    s1_sy <= signed'({~pixel_y[14], pixel_y[13:1]});
    s1_ph <= phase;
  end

  // stage 2: rotation products
  always_ff @(posedge clk) begin
    s2_px <= 28'(ROT_COS) * 28'(s1_sx) + 28'(ROT_SIN) * 28'(s1_sy);
    s2_py <= 28'(ROT_COS) * 28'(s1_sy) - 28'(ROT_SIN) * 28'(s1_sx);
    s2_ph <= s1_ph;
  end

  // stage 3: back to screen units
  always_ff @(posedge clk) begin
    s3_rx <= 15'(sdiv_pow2(40'(s2_px), FRAC_SH));
    s3_ry <= 15'(sdiv_pow2(40'(s2_py), FRAC_SH));
    s3_ph <= s2_ph;
  end

  // squares and width table interpolation terms
  always_comb begin
    rx_sq  = 30'(s3_rx) * 30'(s3_rx);
    ry_sq  = 30'(s3_ry) * 30'(s3_ry);
    ry_abs = s3_ry[14] ? 15'(-s3_ry) : 15'(s3_ry);
    ry_sat = (ry_abs > 15'(WIDTH_SAT)) ? 13'(WIDTH_SAT) : 13'(ry_abs);
    wm     = ry_sat[12:8];
    wf     = ry_sat[7:0];
  end

  // stage 4
  always_ff @(posedge clk) begin
    s4_rx2 <= 27'(rx_sq);
    s4_ry2 <= 27'(ry_sq);
    s4_wa  <= 24'(WIDTH_TAB[{1'b0, wm}]) * 24'(8'd255 - wf);
    s4_wb  <= 24'(WIDTH_TAB[6'({1'b0, wm}) + 6'd1]) * 24'(wf);
    s4_rx  <= s3_rx;
    s4_ry  <= s3_ry;
    s4_ph  <= s3_ph;
  end

  // stage 5: squared radius and width factor
  always_comb begin
    wsum = 25'(s4_wa) + 25'(s4_wb);
  end

  always_ff @(posedge clk) begin
    s5_rad <= 28'(s4_rx2) + 28'(s4_ry2);
    s5_wc  <= 16'(wsum >> WGT_SH);
    s5_rx  <= s4_rx;
    s5_ry  <= s4_ry;
    s5_ph  <= s4_ph;
  end

  // rim darkening from radius squared / 16384, only meaningful inside
  always_comb begin
    rad_q = s5_rad[27:14];
    if (rad_q > 14'(RIM_START)) begin
      rim_val = 9'(14'(RIM_EDGE) - rad_q);
    end else begin
      rim_val = 9'(RIM_FULL);
    end
  end

  // stage 6: inside test and width corrected product
  always_ff @(posedge clk) begin
    s6_txp          <= 32'(s5_rx) * 32'(signed'({1'b0, s5_wc}));
    s6_side.outside <= (s5_rad > 28'(RAD_LIMIT));
    s6_side.rim     <= rim_val;
    s6_ry           <= s5_ry;
    s6_ph           <= s5_ph;
  end

  // stage 7: texture inputs
  always_ff @(posedge clk) begin
    s7_tx   <= 16'(sdiv_pow2(40'(s6_txp), FRAC_SH));
    s7_ty   <= 16'(s6_ry);
    s7_side <= s6_side;
    s7_ph   <= s6_ph;
  end

  // arcsine mapping of both axes, phase added on the horizontal one
  csps_asin u_asin_x (
    .clk    (clk),
    .v      (s7_tx),
    .offset (s7_ph),
    .t      (tex_x)
  );

  csps_asin u_asin_y (
    .clk    (clk),
    .v      (s7_ty),
    .offset (13'd0),
    .t      (tex_y)
  );

  // side info delay
  always_ff @(posedge clk) begin
    side_dly[0] <= s7_side;
    for (int i = 1; i < SIDE_DEPTH; i++) begin
      side_dly[i] <= side_dly[i-1];
    end
  end

  // checker stage 1: edge ramps
  always_ff @(posedge clk) begin
    c1_cx <= edge_ramp(tex_x);
    c1_cy <= edge_ramp(tex_y);
  end

  // checker stage 2: centred product
  always_comb begin
    dx = signed'(10'(c1_cx)) - 10'(CHK_MID);
    dy = signed'(10'(c1_cy)) - 10'(CHK_MID);
  end

  always_ff @(posedge clk) begin
    c2_pc <= 18'(dx) * 18'(dy);
  end

  // checker stage 3: blend factor
  always_ff @(posedge clk) begin
    c3_cc <= 9'(sdiv_pow2(40'(c2_pc), CHK_SH) + 40'(CHK_MID));
  end

  // checker stage 4: green and blue levels
  always_ff @(posedge clk) begin
    c4_g <= 6'((14'(c3_cc) * 14'(GRN_FULL)) >> WGT_SH);
    c4_b <= 5'((14'(c3_cc) * 14'(BLU_FULL)) >> WGT_SH);
  end

  // rim scaling of all three channels
  always_comb begin
    red_p = 14'(side_dly[SIDE_DEPTH-1].rim) * 14'(RED_FULL);
    grn_p = 14'(side_dly[SIDE_DEPTH-1].rim) * 14'(c4_g);
    blu_p = 14'(side_dly[SIDE_DEPTH-1].rim) * 14'(c4_b);
  end

  // output register: pack RGB565, black when outside
  always_ff @(posedge clk) begin
    outside <= side_dly[SIDE_DEPTH-1].outside;
    if (side_dly[SIDE_DEPTH-1].outside) begin
      colour <= 16'd0;
    end else begin
      colour <= {5'(red_p >> WGT_SH), 6'(grn_p >> WGT_SH), 5'(blu_p >> WGT_SH)};
    end
  end

endmodule
